[hw/rtl/acwd_pkg.sv]
// Package for the adaptive chunk work distributor: widths, constants, codes.
// No dependencies.
package acwd_pkg;
    localparam int unsigned DataW          = 32;
    localparam int unsigned SmallW         = 16;
    localparam int unsigned WidW           = 4;
    localparam int unsigned CfgIdxW        = 2;
    localparam int unsigned DefNumWorkers  = 16;
    localparam int unsigned DefFirstClass  = 4;
    localparam int unsigned DefProfStart   = 3;
    localparam logic [DataW-1:0] Sat32     = 32'hFFFF_FFFF;
    localparam logic [5:0] LateDivisor     = 6'd40;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_TOTAL_TASKS = 2'd0,
        CFG_SMALL_CHUNK = 2'd1,
        CFG_BASE_CHUNK  = 2'd2
    } cfg_idx_t;

    typedef enum logic {
        OP_START = 1'b0,
        OP_IDLE  = 1'b1
    } op_t;

    // request to the shared divider
    typedef struct packed {
        logic             start;
        logic [63:0]      dividend;
        logic [DataW-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [63:0]      quotient;
    } div_rsp_t;
endpackage

[hw/rtl/acwd_if.sv]
// Valid/ready channel carrying either a request or a reply payload.
// Depends on acwd_pkg.
interface acwd_req_if;
    logic                       valid;
    logic                       ready;
    logic                       op;
    logic [acwd_pkg::WidW-1:0]  worker_id;
    modport source (output valid, op, worker_id, input ready);
    modport sink   (input valid, op, worker_id, output ready);
endinterface

interface acwd_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [acwd_pkg::WidW-1:0]   grant_worker;
    logic [acwd_pkg::DataW-1:0]  task_start;
    logic [acwd_pkg::DataW-1:0]  chunk_size;
    logic                        stop;
    logic                        all_stopped;
    logic [acwd_pkg::DataW-1:0]  cpu_grants;
    logic [acwd_pkg::DataW-1:0]  gpu_grants;
    modport source (output valid, grant_worker, task_start, chunk_size, stop,
                    all_stopped, cpu_grants, gpu_grants, input ready);
    modport sink   (input valid, grant_worker, task_start, chunk_size, stop,
                    all_stopped, cpu_grants, gpu_grants, output ready);
endinterface

[hw/rtl/acwd_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module acwd_ram #(
    parameter int unsigned Width = 32,
    parameter int unsigned Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] addr,
    input  logic [Width-1:0]         wdata,
    output logic [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

[hw/rtl/acwd_div.sv]
// Shared restoring divider, one quotient bit a cycle (64/32).
// Depends on acwd_pkg.
module acwd_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  acwd_pkg::div_req_t   req,
    output acwd_pkg::div_rsp_t   rsp
);
    import acwd_pkg::*;

    logic [63:0] quo_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic [32:0] shifted;

    assign shifted = {rem_reg, quo_reg[63]};
    assign trial   = shifted - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[32])
            begin
                rem_reg <= trial[31:0];
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[31:0];
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;
endmodule

[hw/rtl/adaptive_chunk_work_distributor_top.sv]
// Adaptive chunk work distributor, top level: sequencer, registers, stores.
// A stop reply goes straight to the output state; a grant first reads the stores,
// decides the chunk and commits it, and a start reply first clears the stores.
// The first grant at or above 2/10 recomputes the block sizes on the shared
// divider: first the divisor, then one block size per worker. One item at a
// time: the next request is taken the cycle after the reply transfer. Reset
// (rst_n, async, low) restores register defaults and a fresh run, then clears
// the per-worker stores before ready rises; a start item runs the same sweep.
module adaptive_chunk_work_distributor_top
    import acwd_pkg::*;
#(
    parameter int unsigned NUM_WORKERS          = acwd_pkg::DefNumWorkers,
    parameter int unsigned FIRST_CLASS_WORKERS  = acwd_pkg::DefFirstClass,
    parameter int unsigned PROFILE_START_WORKER = acwd_pkg::DefProfStart
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [acwd_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [acwd_pkg::DataW-1:0]     cfg_data,
    acwd_req_if.sink                       req,
    acwd_rsp_if.source                     rsp
);
    localparam int unsigned AW = (NUM_WORKERS > 1) ? $clog2(NUM_WORKERS) : 1;
    localparam int unsigned CW = $clog2(NUM_WORKERS + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_CLEAR, S_READ, S_DECIDE, S_DSR_START, S_DSR_WAIT,
        S_RC_READ, S_RC_START, S_RC_WAIT, S_FINAL, S_LATE_DIV, S_COMMIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [DataW-1:0]  total_reg;
    logic [SmallW-1:0] small_reg, base_reg;
    logic [DataW-1:0]  next_task_reg, prof_total_reg, cpu_reg, gpu_reg;
    logic              await_reg, prof_on_reg, pending_reg;
    logic [NUM_WORKERS-1:0] stopped_reg;
    logic [CW-1:0]     stop_cnt_reg;
    logic [WidW-1:0]   wid_reg;
    logic [AW-1:0]     idx_reg;
    logic [DataW-1:0]  chunk_reg;
    logic [DataW-1:0]  divisor_reg;

    // per-worker stores
    logic              gc_we, bs_we;
    logic [AW-1:0]     gc_addr, bs_addr;
    logic [DataW-1:0]  gc_wdata, bs_wdata, gc_rdata, bs_rdata;

    acwd_ram #(.Width(DataW), .Depth(NUM_WORKERS)) u_grant_ram (
        .clk(clk), .we(gc_we), .addr(gc_addr), .wdata(gc_wdata), .rdata(gc_rdata));
    acwd_ram #(.Width(DataW), .Depth(NUM_WORKERS)) u_block_ram (
        .clk(clk), .we(bs_we), .addr(bs_addr), .wdata(bs_wdata), .rdata(bs_rdata));

    div_req_t div_req;
    div_rsp_t div_rsp;
    acwd_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

    logic [AW-1:0] wa;
    assign wa = wid_reg[AW-1:0];

    // progress bands by cross-multiplication on 36-bit values
    logic [35:0] nt10, nt5, tt36, tt4;
    assign nt10 = {4'd0, next_task_reg} * 36'd10;
    assign nt5  = {4'd0, next_task_reg} * 36'd5;
    assign tt36 = {4'd0, total_reg};
    assign tt4  = {2'd0, total_reg, 2'd0};

    // base * grant count for one worker of the recompute pass
    logic [47:0] rc_prod;
    assign rc_prod = {32'd0, base_reg} * {16'd0, gc_rdata};

    logic [DataW-1:0] q_sat;
    assign q_sat = (div_rsp.quotient[63:32] != '0) ? Sat32 : div_rsp.quotient[31:0];

    always_comb
    begin
        gc_we = 1'b0; gc_addr = wa; gc_wdata = '0;
        bs_we = 1'b0; bs_addr = wa; bs_wdata = '0;
        div_req = '0;
        div_req.divisor  = divisor_reg;
        div_req.dividend = {16'd0, rc_prod};
        unique case (state_reg)
            S_CLEAR, S_INIT:
            begin
                gc_we = 1'b1; gc_addr = idx_reg;
                bs_we = 1'b1; bs_addr = idx_reg;
            end
            S_DECIDE:
            begin
                // count grant while the profiling window is open
                if (!(nt10 < tt36) && (nt5 < tt36) && (prof_on_reg
                    || (wid_reg >= WidW'(PROFILE_START_WORKER) && await_reg)))
                begin
                    gc_we    = 1'b1;
                    gc_wdata = (gc_rdata == Sat32) ? gc_rdata : gc_rdata + 32'd1;
                end
            end
            S_DSR_START:
            begin
                // profile total over the worker count, on the shared divider
                div_req.start    = 1'b1;
                div_req.dividend = {32'd0, prof_total_reg};
                div_req.divisor  = DataW'(NUM_WORKERS);
            end
            S_RC_READ:  gc_addr = idx_reg;
            S_RC_START:
            begin
                gc_addr = idx_reg;
                div_req.start = 1'b1;
            end
            S_RC_WAIT:
            begin
                bs_addr = idx_reg;
                if (div_rsp.done)
                begin
                    bs_we = 1'b1; bs_wdata = q_sat;
                end
            end
            default: ;
        endcase
    end

    // division by 40 of the per-worker block size: multiply by reciprocal
    logic [DataW-1:0] bs_div40;
    logic [67:0]      recip_prod;
    assign recip_prod = {36'd0, bs_rdata} * 68'hCCCCCCCD;
    assign bs_div40 = DataW'(recip_prod >> 37);

    assign req.ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            total_reg      <= 32'd1;
            small_reg      <= 16'd64;
            base_reg       <= 16'd256;
            next_task_reg  <= '0;
            prof_total_reg <= '0;
            cpu_reg        <= '0;
            gpu_reg        <= '0;
            await_reg      <= 1'b1;
            prof_on_reg    <= 1'b0;
            pending_reg    <= 1'b1;
            stopped_reg    <= '0;
            stop_cnt_reg   <= '0;
            idx_reg        <= '0;
            divisor_reg    <= 32'd1;
            rsp.valid      <= 1'b0;
            wid_reg        <= '0;
            chunk_reg      <= '0;
            rsp.grant_worker <= '0;
            rsp.task_start <= '0;
            rsp.chunk_size <= '0;
            rsp.stop       <= 1'b0;
            rsp.all_stopped <= 1'b0;
            rsp.cpu_grants <= '0;
            rsp.gpu_grants <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_TOTAL_TASKS: total_reg <= cfg_data;
                    CFG_SMALL_CHUNK: small_reg <= cfg_data[SmallW-1:0];
                    CFG_BASE_CHUNK:  base_reg  <= cfg_data[SmallW-1:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        wid_reg <= req.worker_id;
                        if (req.op == OP_START)
                        begin
                            next_task_reg  <= '0;
                            prof_total_reg <= '0;
                            cpu_reg        <= '0;
                            gpu_reg        <= '0;
                            await_reg      <= 1'b1;
                            prof_on_reg    <= 1'b0;
                            pending_reg    <= 1'b1;
                            stopped_reg    <= '0;
                            stop_cnt_reg   <= '0;
                            idx_reg        <= '0;
                            state_reg      <= S_CLEAR;
                        end
                        else if (32'(req.worker_id) >= NUM_WORKERS)
                        begin
                            rsp.grant_worker <= req.worker_id;
                            rsp.task_start <= '0;
                            rsp.chunk_size <= '0;
                            rsp.stop       <= 1'b0;
                            state_reg      <= S_OUT;
                        end
                        else if (next_task_reg >= total_reg)
                        begin
                            rsp.grant_worker <= req.worker_id;
                            rsp.task_start <= '0;
                            rsp.chunk_size <= '0;
                            rsp.stop       <= 1'b1;
                            if (!stopped_reg[req.worker_id[AW-1:0]])
                            begin
                                stopped_reg[req.worker_id[AW-1:0]] <= 1'b1;
                                stop_cnt_reg <= stop_cnt_reg + CW'(1);
                            end
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_INIT:
                begin
                    // clear the per-worker stores once after reset
                    idx_reg <= idx_reg + AW'(1);
                    if (32'(idx_reg) == NUM_WORKERS - 1)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + AW'(1);
                    if (32'(idx_reg) == NUM_WORKERS - 1)
                    begin
                        rsp.grant_worker <= '0;
                        rsp.task_start <= '0;
                        rsp.chunk_size <= '0;
                        rsp.stop       <= 1'b0;
                        state_reg      <= S_OUT;
                    end
                end
                S_READ: state_reg <= S_DECIDE;
                S_DECIDE:
                begin
                    if (wid_reg >= WidW'(PROFILE_START_WORKER) && await_reg)
                    begin
                        await_reg   <= 1'b0;
                        prof_on_reg <= 1'b1;
                    end
                    if (nt10 < tt36)
                    begin
                        chunk_reg <= {16'd0, small_reg};
                        state_reg <= S_COMMIT;
                    end
                    else if (nt5 < tt36)
                    begin
                        if (prof_on_reg || (wid_reg >= WidW'(PROFILE_START_WORKER)
                                            && await_reg))
                        begin
                            prof_total_reg <= (prof_total_reg == Sat32) ? Sat32
                                            : prof_total_reg + 32'd1;
                        end
                        chunk_reg <= {16'd0, small_reg};
                        state_reg <= S_COMMIT;
                    end
                    else if (pending_reg)
                    begin
                        pending_reg <= 1'b0;
                        idx_reg     <= '0;
                        state_reg   <= S_DSR_START;
                    end
                    else
                    begin
                        state_reg <= S_FINAL;
                    end
                end
                S_DSR_START: state_reg <= S_DSR_WAIT;
                S_DSR_WAIT:
                begin
                    // a zero divisor counts as one
                    if (div_rsp.done)
                    begin
                        divisor_reg <= (div_rsp.quotient[31:0] == '0) ? 32'd1
                                     : div_rsp.quotient[31:0];
                        state_reg   <= S_RC_READ;
                    end
                end
                S_RC_READ:  state_reg <= S_RC_START;
                S_RC_START: state_reg <= S_RC_WAIT;
                S_RC_WAIT:
                begin
                    if (div_rsp.done)
                    begin
                        idx_reg <= idx_reg + AW'(1);
                        state_reg <= (32'(idx_reg) == NUM_WORKERS - 1) ? S_LATE_DIV
                                                                       : S_RC_READ;
                    end
                end
                S_LATE_DIV: state_reg <= S_FINAL;   // block size read settles
                S_FINAL:
                begin
                    chunk_reg <= (nt5 < tt4) ? bs_rdata : bs_div40;
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    logic [DataW-1:0] c;
                    c = (chunk_reg == '0) ? 32'd1 : chunk_reg;
                    rsp.grant_worker <= wid_reg;
                    rsp.task_start <= next_task_reg;
                    rsp.chunk_size <= c;
                    rsp.stop       <= 1'b0;
                    next_task_reg  <= (({1'b0, next_task_reg} + {1'b0, c}) > 33'(Sat32))
                                    ? Sat32 : next_task_reg + c;
                    if (32'(wid_reg) < FIRST_CLASS_WORKERS)
                        cpu_reg <= (cpu_reg == Sat32) ? Sat32 : cpu_reg + 32'd1;
                    else
                        gpu_reg <= (gpu_reg == Sat32) ? Sat32 : gpu_reg + 32'd1;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (!rsp.valid)
                    begin
                        rsp.valid       <= 1'b1;
                        rsp.all_stopped <= (32'(stop_cnt_reg) == NUM_WORKERS);
                        rsp.cpu_grants  <= cpu_reg;
                        rsp.gpu_grants  <= gpu_reg;
                    end
                    else if (rsp.ready)
                    begin
                        rsp.valid <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef SYNTHESIS
    ap_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> !rsp.valid) else $error("ready while reply pending");
    ap_nt_mono: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_CLEAR && $past(state_reg) != S_IDLE)
            |-> next_task_reg >= $past(next_task_reg)) else $error("next_task fell");
    ap_stop_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        32'(stop_cnt_reg) == 32'($countones(stopped_reg))) else $error("stop count");
`endif
endmodule
